/* hdl/dra_pkg.sv */
// ----------------------------------------------------------------------------
// dra_pkg
// Shared widths, opcodes, ALU request type and saturation helpers for the
// daily return aggregator.
// ----------------------------------------------------------------------------
package dra_pkg;

	localparam int DAY_W  = 27;
	localparam int RET_W  = 32;
	localparam int SUM_W  = 52;
	localparam int CUM_W  = 56;
	localparam int MEAN_W = 32;
	localparam int ALU_W  = 57;
	localparam int OP_W   = 2;
	localparam int IN_W   = 96;
	localparam int DIV_CNT_W = $clog2(SUM_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

	localparam logic [OP_W-1:0] OP_TRADE = 2'd0;
	localparam logic [OP_W-1:0] OP_FLUSH = 2'd1;
	localparam logic [OP_W-1:0] OP_START = 2'd2;

	// request to the shared adder/subtractor: y = a + b, or a - b when sub
	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} alu_req_t;

	function automatic logic [SUM_W-1:0] sat_sum(input logic [ALU_W-1:0] r);
		logic [ALU_W-SUM_W:0] hi;
		hi = r[ALU_W-1:SUM_W-1];
		if (&hi || ~|hi) begin
			return r[SUM_W-1:0];
		end else if (r[ALU_W-1]) begin
			return {1'b1, {(SUM_W-1){1'b0}}};
		end else begin
			return {1'b0, {(SUM_W-1){1'b1}}};
		end
	endfunction

	function automatic logic [CUM_W-1:0] sat_cum(input logic [ALU_W-1:0] r);
		logic [ALU_W-CUM_W:0] hi;
		hi = r[ALU_W-1:CUM_W-1];
		if (&hi || ~|hi) begin
			return r[CUM_W-1:0];
		end else if (r[ALU_W-1]) begin
			return {1'b1, {(CUM_W-1){1'b0}}};
		end else begin
			return {1'b0, {(CUM_W-1){1'b1}}};
		end
	endfunction

endpackage

/* hdl/dra_alu.sv */
// ----------------------------------------------------------------------------
// dra_alu
// Shared 57-bit adder/subtractor used for all sums, absolute values and the
// restoring division steps.
// ----------------------------------------------------------------------------
module dra_alu (
	input  dra_pkg::alu_req_t          req,
	output logic [dra_pkg::ALU_W-1:0]  y
);
	import dra_pkg::*;

	assign y = req.a + (req.sub ? ~req.b : req.b) + ALU_W'(req.sub);

endmodule

/* hdl/daily_return_aggregator.sv */
// ----------------------------------------------------------------------------
// daily_return_aggregator
// Groups trade returns by day, emits one summary row per closed day with
// counts, saturating sums, truncated means and the running net return.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Bus      Contents (low bit first)
// s_axis    in   tdata    day_code[26:0], gross_return[58:27], net_return[90:59], pad
//                tuser    opcode[1:0] (0 trade, 1 flush, 2 start)
// m_axis    out  tdata    row_day, trade_count, gross_total, net_total,
//                         gross_mean, net_mean, running_net, pad
//
// Sequence: a trade that closes no day is accepted, then makes three passes
// through the shared adder. A row adds, for each of the two means, one
// absolute-value pass and 52 restoring division steps on the shared adder, then
// the load of the output register. A flush with a row skips the adder passes.
// Reset: arst_n clears all accumulators and the sequencer; no row pending.
// Stalls: a finished row sits in the output register while the next
// transaction is taken; only a second row waits for m_tready.
// ----------------------------------------------------------------------------
module daily_return_aggregator #(
	parameter int COUNT_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// day_code[26:0], gross_return[58:27], net_return[90:59], zero pad
	input  logic [dra_pkg::IN_W-1:0]      s_tdata,
	// opcode[1:0]
	input  logic [dra_pkg::OP_W-1:0]      s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// row_day, trade_count, gross_total, net_total, gross_mean, net_mean,
	// running_net, zero pad
	output logic [((251 + COUNT_BITS + 7) / 8) * 8 - 1:0] m_tdata
);
	import dra_pkg::*;

	localparam int OUT_W = ((251 + COUNT_BITS + 7) / 8) * 8;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_ADD_G = 7'b0000010,
		ST_ADD_N = 7'b0000100,
		ST_ADD_C = 7'b0001000,
		ST_ABS   = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t state_q;

	// day state
	logic [DAY_W-1:0]      open_day_q;
	logic [COUNT_BITS-1:0] day_count_q;
	logic [SUM_W-1:0]      gross_acc_q, net_acc_q;
	logic [CUM_W-1:0]      cum_acc_q;

	// latched trade returns
	logic [RET_W-1:0] gin_q, nin_q;
	logic             row_pend_q;

	// snapshot of the closing day
	logic [DAY_W-1:0]      row_day_q;
	logic [COUNT_BITS-1:0] row_cnt_q;
	logic [SUM_W-1:0]      row_gross_q, row_net_q;
	logic [CUM_W-1:0]      row_cum_q;

	// divider
	logic                  div_net_q;
	logic [SUM_W-1:0]      dq_q;      // dividend shifts out, quotient shifts in
	logic [COUNT_BITS-1:0] rem_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic [MEAN_W-1:0]     mean_g_q, mean_n_q;

	logic [OUT_W-1:0] out_q;
	logic             out_vld_q;
	logic             emit_go;

	// input decode
	logic [DAY_W-1:0] in_day;
	logic [RET_W-1:0] in_g, in_n;
	logic             acc_in, is_trade, close_now, has_row;

	assign in_day = s_tdata[DAY_W-1:0];
	assign in_g   = s_tdata[DAY_W+RET_W-1:DAY_W];
	assign in_n   = s_tdata[DAY_W+2*RET_W-1:DAY_W+RET_W];

	assign s_tready = (state_q == ST_IDLE);
	assign acc_in   = s_tvalid && s_tready;
	assign has_row  = (open_day_q != '0) && (day_count_q != '0);
	assign is_trade = (s_tuser == OP_TRADE) && (in_day != '0);
	assign close_now = is_trade && has_row && (in_day != open_day_q);

	// row moves into the output register once that register is free
	assign emit_go = (state_q == ST_EMIT) && (!out_vld_q || m_tready);

	// shared unit
	alu_req_t         alu_req;
	logic [ALU_W-1:0] alu_y;
	logic [SUM_W-1:0] div_src;
	logic [COUNT_BITS:0] trial;
	logic             fits;

	assign div_src = div_net_q ? row_net_q : row_gross_q;
	assign trial   = {rem_q, dq_q[SUM_W-1]};
	assign fits    = !alu_y[ALU_W-1];

	always_comb begin
		alu_req = '0;
		unique case (state_q)
			ST_ADD_G: begin
				alu_req.a = {{(ALU_W-SUM_W){gross_acc_q[SUM_W-1]}}, gross_acc_q};
				alu_req.b = {{(ALU_W-RET_W){gin_q[RET_W-1]}}, gin_q};
			end
			ST_ADD_N: begin
				alu_req.a = {{(ALU_W-SUM_W){net_acc_q[SUM_W-1]}}, net_acc_q};
				alu_req.b = {{(ALU_W-RET_W){nin_q[RET_W-1]}}, nin_q};
			end
			ST_ADD_C: begin
				alu_req.a = {{(ALU_W-CUM_W){cum_acc_q[CUM_W-1]}}, cum_acc_q};
				alu_req.b = {{(ALU_W-RET_W){nin_q[RET_W-1]}}, nin_q};
			end
			ST_ABS: begin
				// 0 - x for negative sums, 0 + x otherwise
				alu_req.b   = {{(ALU_W-SUM_W){div_src[SUM_W-1]}}, div_src};
				alu_req.sub = div_src[SUM_W-1];
			end
			ST_DIV: begin
				alu_req.a   = {{(ALU_W-COUNT_BITS-1){1'b0}}, trial};
				alu_req.b   = {{(ALU_W-COUNT_BITS){1'b0}}, row_cnt_q};
				alu_req.sub = 1'b1;
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	dra_alu u_alu (
		.req (alu_req),
		.y   (alu_y)
	);

	// clamp quotient magnitude to the 32-bit signed range and apply sign
	logic [SUM_W-1:0]  q_final;
	logic [MEAN_W-1:0] mean_val;
	logic              q_big_pos, q_big_neg;

	assign q_final   = {dq_q[SUM_W-2:0], fits};
	assign q_big_pos = (|q_final[SUM_W-1:MEAN_W-1]);
	assign q_big_neg = (|q_final[SUM_W-1:MEAN_W]) ||
		(q_final[MEAN_W-1] && (|q_final[MEAN_W-2:0]));

	always_comb begin
		if (div_src[SUM_W-1]) begin
			mean_val = q_big_neg ? {1'b1, {(MEAN_W-1){1'b0}}} :
				(~q_final[MEAN_W-1:0] + MEAN_W'(1));
		end else begin
			mean_val = q_big_pos ? {1'b0, {(MEAN_W-1){1'b1}}} : q_final[MEAN_W-1:0];
		end
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			open_day_q  <= '0;
			day_count_q <= '0;
			gross_acc_q <= '0;
			net_acc_q   <= '0;
			cum_acc_q   <= '0;
			row_pend_q  <= 1'b0;
			div_net_q   <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						div_net_q <= 1'b0;
						priority if (s_tuser == OP_START) begin
							open_day_q  <= '0;
							day_count_q <= '0;
							gross_acc_q <= '0;
							net_acc_q   <= '0;
							cum_acc_q   <= '0;
						end else if (s_tuser == OP_FLUSH) begin
							if (has_row) begin
								day_count_q <= '0;
								gross_acc_q <= '0;
								net_acc_q   <= '0;
								state_q     <= ST_ABS;
							end
						end else if (is_trade) begin
							open_day_q <= in_day;
							row_pend_q <= close_now;
							if (close_now) begin
								day_count_q <= COUNT_BITS'(1);
								gross_acc_q <= '0;
								net_acc_q   <= '0;
							end else if (!(&day_count_q)) begin
								day_count_q <= day_count_q + COUNT_BITS'(1);
							end
							state_q <= ST_ADD_G;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ADD_G: begin
					gross_acc_q <= sat_sum(alu_y);
					state_q     <= ST_ADD_N;
				end
				ST_ADD_N: begin
					net_acc_q <= sat_sum(alu_y);
					state_q   <= ST_ADD_C;
				end
				ST_ADD_C: begin
					cum_acc_q <= sat_cum(alu_y);
					state_q   <= row_pend_q ? ST_ABS : ST_IDLE;
				end
				ST_ABS: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_LAST) begin
						if (div_net_q) begin
							state_q <= ST_EMIT;
						end else begin
							div_net_q <= 1'b1;
							state_q   <= ST_ABS;
						end
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output valid: set on a new row, cleared when the row is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_go) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc_in) begin
			gin_q <= in_g;
			nin_q <= in_n;
			// snapshot is taken before this transaction touches the sums
			row_day_q   <= open_day_q;
			row_cnt_q   <= day_count_q;
			row_gross_q <= gross_acc_q;
			row_net_q   <= net_acc_q;
			row_cum_q   <= cum_acc_q;
		end
		if (state_q == ST_ABS) begin
			dq_q  <= alu_y[SUM_W-1:0];
			rem_q <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_q <= fits ? alu_y[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			dq_q  <= q_final;
			if (div_cnt_q == DIV_LAST) begin
				if (div_net_q) begin
					mean_n_q <= mean_val;
				end else begin
					mean_g_q <= mean_val;
				end
			end
		end
		if (emit_go) begin
			out_q <= OUT_W'({row_cum_q, mean_n_q, mean_g_q, row_net_q, row_gross_q,
				row_cnt_q, row_day_q});
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

`ifndef SYNTHESIS
	a_count_needs_day: assert property (@(posedge clk) disable iff (!arst_n)
		(open_day_q == '0) |-> (day_count_q == '0))
		else $error("trades counted with no open day");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (row_cnt_q != '0))
		else $error("division by zero count");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && s_tuser == OP_START) |=>
		(open_day_q == '0 && cum_acc_q == '0 && state_q == ST_IDLE))
		else $error("start did not clear state");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && (!out_vld_q || m_tready)) |=>
		(out_vld_q && state_q == ST_IDLE))
		else $error("row not loaded into output register");
`endif

endmodule
